### src/sfi_pkg.sv
// ---------------------------------------------------------------------------
// sfi_pkg: shared types and constants of the stereo FIR interpolator
// Field widths, Q-format limits, item kind codes, register indexes, the
// sequencer state type and the control bundles between the sub-blocks.
// ---------------------------------------------------------------------------
package sfi_pkg;

   // Q1.23 sample and coefficient format
   localparam int SAMPLE_W   = 24;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int FRAC_BITS  = 23;
   localparam int Q_MAX      = 8388607;
   localparam int Q_MIN      = -8388608;

   // Field and register widths
   localparam int COEF_IDX_W = 7;
   localparam int RATIO_W    = 5;
   localparam int TAPS_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_L   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT = 2'd1;

   // Register reset values
   localparam logic [RATIO_W-1:0] RATIO_RESET = 5'd1;
   localparam logic [TAPS_W-1:0]  TAPS_RESET  = 8'd128;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_MAC,
      ST_DRAIN,
      ST_SCALE,
      ST_ROUND
   } sfi_state_type;

   // Commands to the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic issue;
      logic scale;
   } sfi_mac_ctl_type;

   // Sequencer status toward the top level
   typedef struct packed {
      logic req_ready;
      logic clearing;
      logic write_sample;
      logic zero_fill;
      logic out_load;
      logic out_last;
   } sfi_seq_flags_type;

endpackage

### src/sfi_if.sv
// ---------------------------------------------------------------------------
// sfi_if: channel interfaces of the stereo FIR interpolator
// Request, response and register write channels, each valid/ready with
// a source and a sink modport.
// ---------------------------------------------------------------------------

// Input items: stereo samples or coefficient loads
interface sfi_req_if;
   import sfi_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [SAMPLE_W-1:0]   left_sample;
   logic signed [SAMPLE_W-1:0]   right_sample;
   logic        [COEF_IDX_W-1:0] coef_index;
   logic signed [SAMPLE_W-1:0]   coef_value;

   modport source (output valid, kind, left_sample, right_sample, coef_index, coef_value,
                   input ready);
   modport sink   (input valid, kind, left_sample, right_sample, coef_index, coef_value,
                   output ready);
endinterface

// Result items: interpolated stereo pair
interface sfi_rsp_if;
   import sfi_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   logic                       last;

   modport source (output valid, left_out, right_out, last, input ready);
   modport sink   (input valid, left_out, right_out, last, output ready);
endinterface

// Register writes
interface sfi_csr_if;
   import sfi_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/sfi_ram.sv
// ---------------------------------------------------------------------------
// sfi_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module sfi_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sfi_mac.sv
// ---------------------------------------------------------------------------
// sfi_mac: shared two-lane multiply-accumulate unit
// One tap product per lane per cycle, accumulation, gain by the ratio,
// then rounding to Q1.23 with saturation.
// ---------------------------------------------------------------------------
module sfi_mac #(
   parameter int MAX_TAPS  = 128,
   parameter int MAX_RATIO = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sfi_pkg::sfi_mac_ctl_type               ctl,
   input  logic [$clog2(MAX_RATIO+1)-1:0]         lr_eff,
   input  logic signed [sfi_pkg::SAMPLE_W-1:0]    rd_left,
   input  logic signed [sfi_pkg::SAMPLE_W-1:0]    rd_right,
   input  logic signed [sfi_pkg::SAMPLE_W-1:0]    rd_coef,
   output logic signed [sfi_pkg::SAMPLE_W-1:0]    left_q,
   output logic signed [sfi_pkg::SAMPLE_W-1:0]    right_q
);
   import sfi_pkg::*;

   localparam int AW   = $clog2(MAX_TAPS);
   localparam int RW   = $clog2(MAX_RATIO+1);
   localparam int ACCW = PROD_W + AW;
   localparam int SCW  = ACCW + RW + 1;
   localparam int QW   = SCW + 1 - FRAC_BITS;

   localparam logic signed [SCW:0]  HALF_LSB = (SCW+1)'(1) << (FRAC_BITS - 1);
   localparam logic signed [QW-1:0] SAT_HI   = QW'(Q_MAX);
   localparam logic signed [QW-1:0] SAT_LO   = QW'(Q_MIN);

   // Round half up to Q1.23, then clamp
   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [SCW-1:0] v
   );
      logic signed [SCW:0]  r;
      logic signed [QW-1:0] q;
      logic signed [SAMPLE_W-1:0] res;
      r = (SCW+1)'(v) + HALF_LSB;
      q = r[SCW:FRAC_BITS];
      if (q > SAT_HI) begin
         res = SAMPLE_W'(SAT_HI);
      end else if (q < SAT_LO) begin
         res = SAMPLE_W'(SAT_LO);
      end else begin
         res = SAMPLE_W'(q);
      end
      return res;
   endfunction

   logic                     rv_ff, rv_in;
   logic                     pv_ff, pv_in;
   logic signed [PROD_W-1:0] prod_l_ff, prod_l_in;
   logic signed [PROD_W-1:0] prod_r_ff, prod_r_in;
   logic signed [ACCW-1:0]   acc_l_ff, acc_l_in;
   logic signed [ACCW-1:0]   acc_r_ff, acc_r_in;
   logic signed [SCW-1:0]    sc_l_ff, sc_l_in;
   logic signed [SCW-1:0]    sc_r_ff, sc_r_in;
   logic signed [RW:0]       gain;

   // Valid tags follow the RAM read and the product register
   always_comb begin
      rv_in = ctl.issue;
      pv_in = rv_ff;
   end

   // Tap products
   always_comb begin
      prod_l_in = rd_left * rd_coef;
      prod_r_in = rd_right * rd_coef;
   end

   // Accumulate
   always_comb begin
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      if (ctl.clear) begin
         acc_l_in = '0;
         acc_r_in = '0;
      end else if (pv_ff) begin
         acc_l_in = acc_l_ff + ACCW'(prod_l_ff);
         acc_r_in = acc_r_ff + ACCW'(prod_r_ff);
      end
   end

   // Gain by L
   assign gain = $signed({1'b0, lr_eff});

   always_comb begin
      sc_l_in = sc_l_ff;
      sc_r_in = sc_r_ff;
      if (ctl.scale) begin
         sc_l_in = SCW'(acc_l_ff) * SCW'(gain);
         sc_r_in = SCW'(acc_r_ff) * SCW'(gain);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
      acc_l_ff  <= acc_l_in;
      acc_r_ff  <= acc_r_in;
      sc_l_ff   <= sc_l_in;
      sc_r_ff   <= sc_r_in;
   end

   assign left_q  = round_sat(sc_l_ff);
   assign right_q = round_sat(sc_r_ff);

endmodule

### src/sfi_seq.sv
// ---------------------------------------------------------------------------
// sfi_seq: sequencer of the stereo FIR interpolator
// Clearing pass, delay line writes, tap walk, drain, gain and output
// phases for each of the L results of a sample item.
// ---------------------------------------------------------------------------
module sfi_seq #(
   parameter int MAX_TAPS  = 128,
   parameter int MAX_RATIO = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(MAX_TAPS+1)-1:0]       taps_eff,
   input  logic [$clog2(MAX_RATIO+1)-1:0]      lr_eff,
   input  logic                                req_fire,
   input  logic                                req_kind,
   input  logic                                out_free,
   output sfi_pkg::sfi_mac_ctl_type            mac_ctl,
   output sfi_pkg::sfi_seq_flags_type          flags,
   output logic [$clog2(MAX_TAPS)-1:0]         clr_addr,
   output logic [$clog2(MAX_TAPS)-1:0]         wr_addr,
   output logic [$clog2(MAX_TAPS)-1:0]         dl_rd_addr,
   output logic [$clog2(MAX_TAPS)-1:0]         cf_rd_addr
);
   import sfi_pkg::*;

   localparam int AW = $clog2(MAX_TAPS);
   localparam int TW = $clog2(MAX_TAPS+1);
   localparam int RW = $clog2(MAX_RATIO+1);
   localparam int PW = $clog2(MAX_RATIO);

   sfi_state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [AW-1:0] tap_ff, tap_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic          drain_ff, drain_in;

   logic [AW-1:0] wr_addr_c;
   logic [TW-1:0] wpos_inc;
   logic [AW-1:0] wpos_next;
   logic          clr_done;
   logic          tap_last;
   logic          phase_last;
   logic          sample_fire;

   // Position arithmetic; a stale write position restarts at zero
   always_comb begin
      wr_addr_c   = (TW'(wpos_ff) >= taps_eff) ? '0 : wpos_ff;
      wpos_inc    = TW'(wr_addr_c) + TW'(1);
      wpos_next   = (wpos_inc >= taps_eff) ? '0 : AW'(wpos_inc);
      clr_done    = (clr_ff == AW'(MAX_TAPS - 1));
      tap_last    = (TW'(tap_ff) == taps_eff - TW'(1));
      phase_last  = (RW'(phase_ff) == lr_eff - RW'(1));
      sample_fire = req_fire && (req_kind == KIND_SAMPLE);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_done) state_in = ST_IDLE;
         ST_IDLE:  if (sample_fire) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_MAC;
         ST_MAC:   if (tap_last) state_in = ST_DRAIN;
         ST_DRAIN: if (drain_ff) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ROUND;
         ST_ROUND: begin
            if (out_free) begin
               state_in = phase_last ? ST_IDLE : ST_WRITE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Counters and positions
   always_comb begin
      clr_in   = clr_ff;
      wpos_in  = wpos_ff;
      phase_in = phase_ff;
      tap_in   = tap_ff;
      rd_in    = rd_ff;
      drain_in = drain_ff;
      unique case (state_ff)
         ST_CLEAR: clr_in = clr_ff + AW'(1);
         ST_IDLE:  if (sample_fire) phase_in = '0;
         ST_WRITE: begin
            wpos_in = wpos_next;
            tap_in  = '0;
            rd_in   = wr_addr_c;
         end
         ST_MAC: begin
            tap_in   = tap_ff + AW'(1);
            rd_in    = (rd_ff == '0) ? AW'(taps_eff - TW'(1)) : rd_ff - AW'(1);
            drain_in = 1'b0;
         end
         ST_DRAIN: drain_in = 1'b1;
         ST_SCALE: ;
         ST_ROUND: begin
            if (out_free) begin
               phase_in = phase_last ? '0 : phase_ff + PW'(1);
            end
         end
         default: ;
      endcase
   end

   // Outputs
   always_comb begin
      mac_ctl            = '0;
      flags              = '0;
      flags.zero_fill    = (phase_ff != '0);
      flags.out_last     = phase_last;
      unique case (state_ff)
         ST_CLEAR: flags.clearing = 1'b1;
         ST_IDLE:  flags.req_ready = 1'b1;
         ST_WRITE: begin
            flags.write_sample = 1'b1;
            mac_ctl.clear      = 1'b1;
         end
         ST_MAC:   mac_ctl.issue = 1'b1;
         ST_DRAIN: ;
         ST_SCALE: mac_ctl.scale = 1'b1;
         ST_ROUND: flags.out_load = out_free;
         default: ;
      endcase
   end

   assign clr_addr   = clr_ff;
   assign wr_addr    = wr_addr_c;
   assign dl_rd_addr = rd_ff;
   assign cf_rd_addr = tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         wpos_ff  <= '0;
         phase_ff <= '0;
         tap_ff   <= '0;
         rd_ff    <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         wpos_ff  <= wpos_in;
         phase_ff <= phase_in;
         tap_ff   <= tap_in;
         rd_ff    <= rd_in;
         drain_ff <= drain_in;
      end
   end

endmodule

### src/stereo_fir_interpolator.sv
// ---------------------------------------------------------------------------
// stereo_fir_interpolator: stereo zero-stuffing FIR interpolator
// Upsamples by L through a shared coefficient table and two circular
// delay lines, one multiply-accumulate per channel per cycle.
//
//   channel  | direction | handshake   | payload
//   ---------+-----------+-------------+---------------------------------------
//   req_ch   | in        | valid/ready | kind, left/right_sample, coef_index/value
//   rsp_ch   | out       | valid/ready | left_out, right_out, last
//   csr_ch   | in        | valid/ready | index, data (ratio_l, tap_count)
//
// A sample item keeps req_ch not ready after it is taken until all L results
// have been loaded: per result one write, one tap per cycle on the shared
// multiply-accumulate unit, drain, gain, round. A coefficient load leaves
// req_ch ready for the next item.
// A full output register holds the round step until the result is taken.
// After reset a clearing pass over all MAX_TAPS addresses zeroes the delay
// lines and coefficient table; req_ch is not ready meanwhile, register
// writes are taken throughout.
// ---------------------------------------------------------------------------
module stereo_fir_interpolator #(
   parameter int MAX_TAPS  = 128,
   parameter int MAX_RATIO = 16
) (
   input logic       clock,
   input logic       reset,
   sfi_req_if.sink   req_ch,
   sfi_rsp_if.source rsp_ch,
   sfi_csr_if.sink   csr_ch
);
   import sfi_pkg::*;

   localparam int AW = $clog2(MAX_TAPS);
   localparam int TW = $clog2(MAX_TAPS+1);
   localparam int RW = $clog2(MAX_RATIO+1);

   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [TAPS_W-1:0]  taps_ff, taps_in;
   logic [RW-1:0]      lr_eff;
   logic [TW-1:0]      taps_eff;

   logic signed [SAMPLE_W-1:0] smp_l_ff, smp_l_in;
   logic signed [SAMPLE_W-1:0] smp_r_ff, smp_r_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] out_l_ff, out_l_in;
   logic signed [SAMPLE_W-1:0] out_r_ff, out_r_in;
   logic                       last_ff, last_in;

   sfi_mac_ctl_type   mac_ctl;
   sfi_seq_flags_type flags;
   logic [AW-1:0]     clr_addr, wr_addr, dl_rd_addr, cf_rd_addr;

   logic                       req_fire, coef_ok, out_free;
   logic                       dl_we, cf_we;
   logic [AW-1:0]              dl_waddr, cf_waddr;
   logic signed [SAMPLE_W-1:0] dl_l_wdata, dl_r_wdata, cf_wdata;
   logic signed [SAMPLE_W-1:0] rd_left, rd_right, rd_coef;
   logic signed [SAMPLE_W-1:0] left_q, right_q;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      ratio_in = ratio_ff;
      taps_in  = taps_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_RATIO_L:   ratio_in = csr_ch.data[RATIO_W-1:0];
            CSR_TAP_COUNT: taps_in  = csr_ch.data[TAPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective ratio and tap count, clamped to the supported range
   always_comb begin
      if (ratio_ff == '0) begin
         lr_eff = RW'(1);
      end else if (32'(ratio_ff) > 32'(MAX_RATIO)) begin
         lr_eff = RW'(MAX_RATIO);
      end else begin
         lr_eff = RW'(ratio_ff);
      end
      if (taps_ff == '0) begin
         taps_eff = TW'(1);
      end else if (32'(taps_ff) > 32'(MAX_TAPS)) begin
         taps_eff = TW'(MAX_TAPS);
      end else begin
         taps_eff = TW'(taps_ff);
      end
   end

   // Input handshake
   assign req_ch.ready = flags.req_ready;
   assign req_fire     = req_ch.valid && flags.req_ready;
   assign coef_ok      = req_fire && (req_ch.kind == KIND_COEF) &&
                         (32'(req_ch.coef_index) < 32'(MAX_TAPS));

   always_comb begin
      smp_l_in = smp_l_ff;
      smp_r_in = smp_r_ff;
      if (req_fire && (req_ch.kind == KIND_SAMPLE)) begin
         smp_l_in = req_ch.left_sample;
         smp_r_in = req_ch.right_sample;
      end
   end

   // Memory write ports
   always_comb begin
      dl_we      = flags.clearing || flags.write_sample;
      dl_waddr   = flags.clearing ? clr_addr : wr_addr;
      dl_l_wdata = (flags.clearing || flags.zero_fill) ? '0 : smp_l_ff;
      dl_r_wdata = (flags.clearing || flags.zero_fill) ? '0 : smp_r_ff;
      cf_we      = flags.clearing || coef_ok;
      cf_waddr   = flags.clearing ? clr_addr : AW'(req_ch.coef_index);
      cf_wdata   = flags.clearing ? '0 : req_ch.coef_value;
   end

   sfi_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_left_dl (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_waddr),
      .wr_data (dl_l_wdata),
      .rd_addr (dl_rd_addr),
      .rd_data (rd_left)
   );

   sfi_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_right_dl (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_waddr),
      .wr_data (dl_r_wdata),
      .rd_addr (dl_rd_addr),
      .rd_data (rd_right)
   );

   sfi_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_coef (
      .clock   (clock),
      .wr_en   (cf_we),
      .wr_addr (cf_waddr),
      .wr_data (cf_wdata),
      .rd_addr (cf_rd_addr),
      .rd_data (rd_coef)
   );

   sfi_seq #(.MAX_TAPS(MAX_TAPS), .MAX_RATIO(MAX_RATIO)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .taps_eff   (taps_eff),
      .lr_eff     (lr_eff),
      .req_fire   (req_fire),
      .req_kind   (req_ch.kind),
      .out_free   (out_free),
      .mac_ctl    (mac_ctl),
      .flags      (flags),
      .clr_addr   (clr_addr),
      .wr_addr    (wr_addr),
      .dl_rd_addr (dl_rd_addr),
      .cf_rd_addr (cf_rd_addr)
   );

   sfi_mac #(.MAX_TAPS(MAX_TAPS), .MAX_RATIO(MAX_RATIO)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .lr_eff   (lr_eff),
      .rd_left  (rd_left),
      .rd_right (rd_right),
      .rd_coef  (rd_coef),
      .left_q   (left_q),
      .right_q  (right_q)
   );

   // Output register
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      last_in      = last_ff;
      if (flags.out_load) begin
         rsp_valid_in = 1'b1;
         out_l_in     = left_q;
         out_r_in     = right_q;
         last_in      = flags.out_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = out_l_ff;
   assign rsp_ch.right_out = out_r_ff;
   assign rsp_ch.last      = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff     <= RATIO_RESET;
         taps_ff      <= TAPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         ratio_ff     <= ratio_in;
         taps_ff      <= taps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_l_ff <= smp_l_in;
      smp_r_ff <= smp_r_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
      last_ff  <= last_in;
   end

endmodule

### src/sfi_checker.sv
// ---------------------------------------------------------------------------
// sfi_checker: port-level checks of the stereo FIR interpolator
// Watches the request and response channels and is bound to the top level.
// ---------------------------------------------------------------------------
module sfi_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_kind,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [sfi_pkg::SAMPLE_W-1:0] rsp_left,
   input logic signed [sfi_pkg::SAMPLE_W-1:0] rsp_right,
   input logic                                rsp_last
);
   import sfi_pkg::*;

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left) && $stable(rsp_right) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   // The clearing pass keeps the input closed right after reset
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("input ready during clearing pass");

   // A sample item keeps the block busy on the next cycle
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_SAMPLE) |=> !req_ready)
      else $error("input ready right after a sample item");

   // A coefficient load never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_COEF) && !rsp_valid |=> !rsp_valid)
      else $error("result item after a coefficient load");

endmodule

bind stereo_fir_interpolator sfi_checker u_sfi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_kind  (req_ch.kind),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_left  (rsp_ch.left_out),
   .rsp_right (rsp_ch.right_out),
   .rsp_last  (rsp_ch.last)
);

### bench/sfi_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfi_result_checker: predicts and checks interpolated stereo results
// Watches the request, response and register channels. It keeps its own
// delay lines, coefficient table and register copies, works out the L
// result pairs of every accepted sample item and compares each accepted
// response item, field by field, with the oldest pair still waiting.
// ---------------------------------------------------------------------------
module sfi_result_checker #(
   parameter int MAX_TAPS  = 128,
   parameter int MAX_RATIO = 16
) (
   input  logic clock,
   input  logic reset,
   sfi_req_if   req_ch,
   sfi_rsp_if   rsp_ch,
   sfi_csr_if   csr_ch,
   output int   fail_count,
   output int   pending_results
);
   import sfi_pkg::*;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       last;
   } stereo_pair_type;

   // Local copy of the filter state and registers
   logic signed [SAMPLE_W-1:0] left_hist  [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] right_hist [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] coef_table [MAX_TAPS];
   int                         wr_pos;
   logic [RATIO_W-1:0]         ratio_reg;
   logic [TAPS_W-1:0]          taps_reg;

   stereo_pair_type expected_pairs[$];
   stereo_pair_type want;
   int              mismatches = 0;

   // Gain-scaled Q2.46 sum to Q1.23: add half an LSB, floor, saturate
   function automatic logic signed [SAMPLE_W-1:0] round_q23(input longint acc);
      longint q;
      q = (acc + 64'sd4194304) >>> FRAC_BITS;
      if (q > longint'(Q_MAX)) q = longint'(Q_MAX);
      if (q < longint'(Q_MIN)) q = longint'(Q_MIN);
      return q[SAMPLE_W-1:0];
   endfunction

   // One sample item: L outputs, the sample on the first, zeros stuffed after
   function automatic void interpolate_sample(input logic signed [SAMPLE_W-1:0] xl,
                                              input logic signed [SAMPLE_W-1:0] xr);
      int              n_taps;
      int              n_ratio;
      int              rd;
      longint          acc_l;
      longint          acc_r;
      stereo_pair_type pair;
      n_taps  = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg;
      n_ratio = (ratio_reg == 0) ? 1 : (ratio_reg > MAX_RATIO) ? MAX_RATIO : ratio_reg;
      for (int k = 0; k < n_ratio; k++) begin
         // delay line shrank under the write pointer: restart at the top
         if (wr_pos >= n_taps) wr_pos = 0;
         left_hist[wr_pos]  = (k == 0) ? xl : '0;
         right_hist[wr_pos] = (k == 0) ? xr : '0;
         acc_l = 0;
         acc_r = 0;
         rd    = wr_pos;
         for (int i = 0; i < n_taps; i++) begin
            acc_l += longint'(left_hist[rd]) * longint'(coef_table[i]);
            acc_r += longint'(right_hist[rd]) * longint'(coef_table[i]);
            rd = (rd == 0) ? n_taps - 1 : rd - 1;
         end
         pair.left  = round_q23(acc_l * n_ratio);
         pair.right = round_q23(acc_r * n_ratio);
         pair.last  = (k == n_ratio - 1);
         expected_pairs.push_back(pair);
         wr_pos = (wr_pos + 1 >= n_taps) ? 0 : wr_pos + 1;
      end
   endfunction

   // Channel monitor: responses are checked before new requests are predicted
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            left_hist[i]  = '0;
            right_hist[i] = '0;
            coef_table[i] = '0;
         end
         wr_pos    = 0;
         ratio_reg = RATIO_RESET;
         taps_reg  = TAPS_RESET;
         expected_pairs.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_RATIO_L:   ratio_reg = csr_ch.data[RATIO_W-1:0];
               CSR_TAP_COUNT: taps_reg  = csr_ch.data[TAPS_W-1:0];
               default: ;
            endcase
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pairs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t unexpected result item: L=%0d R=%0d last=%0b", $realtime,
                           rsp_ch.left_out, rsp_ch.right_out, rsp_ch.last);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_ch.left_out !== want.left || rsp_ch.right_out !== want.right ||
                   rsp_ch.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t mismatch: exp L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                              $realtime, want.left, want.right, want.last,
                              rsp_ch.left_out, rsp_ch.right_out, rsp_ch.last);
               end
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.kind == KIND_COEF) begin
               if (req_ch.coef_index < MAX_TAPS)
                  coef_table[req_ch.coef_index] = req_ch.coef_value;
            end else begin
               interpolate_sample(req_ch.left_sample, req_ch.right_sample);
            end
         end
      end
      fail_count      <= mismatches;
      pending_results <= expected_pairs.size();
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench of the stereo FIR interpolator
// Drives a short directed run at the reset settings (extremes, rounding
// ties, saturation), then random sample and coefficient-load items over a
// series of ratio and tap settings, with random gaps on both channels, a
// long response hold-off and a mid-run drain. The checker beside the block
// predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;
   import sfi_pkg::*;

   localparam int TB_MAX_TAPS  = 128;
   localparam int TB_MAX_RATIO = 16;
   localparam int N_PHASES     = 9;
   localparam int HOLD_CYCLES  = 600;

   // Full-scale Q1.23 values
   localparam logic signed [SAMPLE_W-1:0] FULL_POS = SAMPLE_W'(Q_MAX);
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = SAMPLE_W'(Q_MIN);

   // Register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // Settings per random phase: ratio, tap count, item count
   localparam logic [CSR_DATA_W-1:0] PHASE_RATIO [N_PHASES] =
      '{8'd0, 8'd2, 8'd16, 8'd31, 8'd5, 8'd3, 8'd1, 8'd8, 8'hE4};
   localparam logic [CSR_DATA_W-1:0] PHASE_TAPS [N_PHASES] =
      '{8'd0, 8'd4, 8'd8, 8'd255, 8'd16, 8'd3, 8'd128, 8'd33, 8'd10};
   localparam int PHASE_ITEMS [N_PHASES] = '{30, 40, 30, 8, 40, 40, 20, 40, 35};

   logic clock = 1'b0;
   logic reset;
   bit   idle_on = 1'b1;
   logic hold_request = 1'b0;
   int   mismatch_total;
   int   pending_total;

   sfi_req_if req_ch ();
   sfi_rsp_if rsp_ch ();
   sfi_csr_if csr_ch ();

   stereo_fir_interpolator #(
      .MAX_TAPS  (TB_MAX_TAPS),
      .MAX_RATIO (TB_MAX_RATIO)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sfi_result_checker #(
      .MAX_TAPS  (TB_MAX_TAPS),
      .MAX_RATIO (TB_MAX_RATIO)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .fail_count      (mismatch_total),
      .pending_results (pending_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Q1.23 value: full scale, small, or any
   function automatic logic signed [SAMPLE_W-1:0] random_q23();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0: return SAMPLE_W'(Q_MAX);
         1: return SAMPLE_W'(Q_MIN);
         2: return {{8{r[15]}}, r[15:0]};
         default: return r[SAMPLE_W-1:0];
      endcase
   endfunction

   // Filler for fields the block ignores
   function automatic logic signed [SAMPLE_W-1:0] any_word();
      return SAMPLE_W'($urandom);
   endfunction

   function automatic logic [COEF_IDX_W-1:0] any_index();
      return COEF_IDX_W'($urandom);
   endfunction

   // Offer one item, with random gaps first, and wait for it to be taken
   task automatic send_item(input logic                       kind,
                            input logic signed [SAMPLE_W-1:0]  left,
                            input logic signed [SAMPLE_W-1:0]  right,
                            input logic [COEF_IDX_W-1:0]       index,
                            input logic signed [SAMPLE_W-1:0]  coef);
      while (idle_on && $urandom_range(0, 99) < 28) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.left_sample  <= left;
      req_ch.right_sample <= right;
      req_ch.coef_index   <= index;
      req_ch.coef_value   <= coef;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering, wait for every expected pair, then let a load finish
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_total != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Response side: random stalls, plus a long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request <= 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_on && $urandom_range(0, 99) < 28);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int tap_top;
      logic [COEF_IDX_W-1:0] idx;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.kind         <= KIND_SAMPLE;
      req_ch.left_sample  <= '0;
      req_ch.right_sample <= '0;
      req_ch.coef_index   <= '0;
      req_ch.coef_value   <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= '0;
      csr_ch.data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings (ratio 1, 128 taps)
      // all-zero table gives zero output
      send_item(KIND_SAMPLE, FULL_POS, FULL_NEG, any_index(), any_word());
      send_item(KIND_COEF, any_word(), any_word(), 7'd0, FULL_POS);
      send_item(KIND_COEF, any_word(), any_word(), 7'd127, FULL_NEG);
      send_item(KIND_SAMPLE, FULL_POS, FULL_NEG, any_index(), any_word());
      send_item(KIND_SAMPLE, FULL_NEG, FULL_POS, any_index(), any_word());
      // single half-scale tap: rounding ties go toward plus infinity
      send_item(KIND_COEF, any_word(), any_word(), 7'd0, 24'sh400000);
      send_item(KIND_COEF, any_word(), any_word(), 7'd127, '0);
      send_item(KIND_SAMPLE, 24'sd1, -24'sd1, any_index(), any_word());
      send_item(KIND_SAMPLE, 24'sd3, -24'sd3, any_index(), any_word());
      send_item(KIND_SAMPLE, FULL_POS, FULL_NEG, any_index(), any_word());
      // minus one times minus one overflows and saturates
      send_item(KIND_COEF, any_word(), any_word(), 7'd0, FULL_NEG);
      send_item(KIND_SAMPLE, FULL_NEG, FULL_POS, any_index(), any_word());
      send_item(KIND_COEF, any_word(), any_word(), 7'd85, 24'sh555555);
      send_item(KIND_COEF, any_word(), any_word(), 7'd42, 24'shAAAAAA);
      send_item(KIND_SAMPLE, -24'sd1, 24'sd0, any_index(), any_word());
      drain_results();

      // undecoded register indexes must not disturb anything
      write_reg(CSR_SPARE_2, CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_3, CSR_DATA_W'($urandom));

      // Random phases over the register settings
      for (int p = 0; p < N_PHASES; p++) begin
         drain_results();
         write_reg(CSR_RATIO_L, PHASE_RATIO[p]);
         write_reg(CSR_TAP_COUNT, PHASE_TAPS[p]);
         tap_top = (PHASE_TAPS[p] == 0) ? 0 :
                   (PHASE_TAPS[p] >= TB_MAX_TAPS) ? TB_MAX_TAPS - 1 : PHASE_TAPS[p] - 1;
         idle_on = (p != 4);
         // long response stall so the block backs up into its input
         if (p == 1) hold_request <= 1'b1;
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            if (p == 7 && n == 20) drain_results();
            if ($urandom_range(0, 99) < 30) begin
               idx = ($urandom_range(0, 9) < 7)
                     ? COEF_IDX_W'($urandom_range(0, tap_top))
                     : COEF_IDX_W'($urandom_range(0, TB_MAX_TAPS - 1));
               send_item(KIND_COEF, any_word(), any_word(), idx, random_q23());
            end else begin
               send_item(KIND_SAMPLE, random_q23(), random_q23(), any_index(),
                         random_q23());
            end
         end
      end
      idle_on = 1'b1;
      drain_results();
      repeat (30) @(posedge clock);

      if (mismatch_total == 0 && pending_total == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #50_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

### sim.f
src/sfi_pkg.sv
src/sfi_if.sv
src/sfi_ram.sv
src/sfi_mac.sv
src/sfi_seq.sv
src/stereo_fir_interpolator.sv
src/sfi_checker.sv
bench/sfi_result_checker.sv
bench/tb_top.sv
